@@ rtl/core/brf_pkg.sv @@
// Shared types and constants for the byte ring FIFO.
`timescale 1ns / 1ps

package brf_pkg;

  localparam int unsigned DepthDefault = 1024;

  localparam int unsigned CfgW  = 11;
  localparam int unsigned FuncW = 2;
  localparam int unsigned DataW = 8;
  localparam int unsigned CntW  = 10;

  localparam logic [CntW-1:0] BurstMax = {CntW{1'b1}};

  localparam logic [FuncW-1:0] FuncWrite = 2'd0;
  localparam logic [FuncW-1:0] FuncRead  = 2'd1;
  localparam logic [FuncW-1:0] FuncClear = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [DataW-1:0] data_in;
    logic             burst_end;
  } brf_in_t;

  typedef struct packed {
    logic             accepted;
    logic [DataW-1:0] read_data;
    logic [CntW-1:0]  data_count;
    logic [CntW-1:0]  free_space;
    logic             is_full;
    logic             is_empty;
    logic [CntW-1:0]  burst_count;
  } brf_out_t;

endpackage

@@ rtl/core/brf_ram.sv @@
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module brf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/byte_ring_fifo.sv @@
// Byte ring FIFO top level: pointer control, burst count and output register.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------
//   in       | in_valid_i / in_ready_o | in_data_i   (brf_in_t)
//   out      | out_valid_o/out_ready_i | out_data_o  (brf_out_t)
//   cfg      | cfg_we_i                | cfg_wdata_i (queue size)
//
// Write, clear and refused transactions go straight to the output register; an
// accepted read first waits in StRead for the registered read data of the RAM.
// A result waiting in the output register holds the input until it is taken.
// Reset clears both pointers and the burst count and sets the size to Depth;
// the store itself is not cleared. A size write also clears pointers and count.
`timescale 1ns / 1ps

module byte_ring_fifo #(
  parameter int unsigned Depth = brf_pkg::DepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  brf_pkg::brf_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output brf_pkg::brf_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [brf_pkg::CfgW-1:0]  cfg_wdata_i
);

  import brf_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned SzW  = PtrW + 1;
  localparam int unsigned SzQW = (SzW > CfgW) ? SzW : CfgW;

  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;

  logic            state_q, state_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] burst_q, burst_d;
  logic [SzQW-1:0] size_q;
  logic            out_valid_q, out_valid_d;
  brf_out_t        out_q, out_d;

  logic [SzW-1:0]  eff_size;
  logic            size_zero;
  logic [SzW-1:0]  wr_inc, rd_inc;
  logic [PtrW-1:0] wr_next, rd_next;
  logic            can_write, can_read;
  logic            accept;
  logic            acc;
  logic            rd_acc;
  logic            wr_acc;
  logic            clear;
  logic [CntW-1:0] burst_base, burst_cur;
  logic [SzW-1:0]  cnt, space;
  logic [DataW-1:0] ram_rdata;

  assign eff_size  = (32'(size_q) > 32'(Depth)) ? SzW'(Depth) : SzW'(size_q);
  assign size_zero = (eff_size == '0);

  assign wr_inc  = {1'b0, wr_ptr_q} + SzW'(1);
  assign rd_inc  = {1'b0, rd_ptr_q} + SzW'(1);
  assign wr_next = (wr_inc >= eff_size) ? '0 : wr_inc[PtrW-1:0];
  assign rd_next = (rd_inc >= eff_size) ? '0 : rd_inc[PtrW-1:0];

  assign can_write = !size_zero && (wr_next != rd_ptr_q);
  assign can_read  = !size_zero && (wr_ptr_q != rd_ptr_q);

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    acc      = 1'b0;
    rd_acc   = 1'b0;
    wr_acc   = 1'b0;
    clear    = 1'b0;
    if (accept) begin
      case (in_data_i.func)
        FuncWrite: begin
          if (can_write) begin
            wr_ptr_d = wr_next;
            acc      = 1'b1;
            wr_acc   = 1'b1;
          end
        end
        FuncRead: begin
          if (can_read) begin
            rd_ptr_d = rd_next;
            acc      = 1'b1;
            rd_acc   = 1'b1;
          end
        end
        FuncClear: begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          clear    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign burst_base = clear ? '0 : burst_q;
  assign burst_cur  = (acc && (burst_base != BurstMax)) ? burst_base + CntW'(1) : burst_base;

  always_comb begin
    burst_d = burst_q;
    if (accept) begin
      burst_d = in_data_i.burst_end ? '0 : burst_cur;
    end
  end

  always_comb begin
    if (size_zero) begin
      cnt = '0;
    end else if (wr_ptr_d >= rd_ptr_d) begin
      cnt = {1'b0, wr_ptr_d} - {1'b0, rd_ptr_d};
    end else begin
      cnt = eff_size - {1'b0, rd_ptr_d} + {1'b0, wr_ptr_d};
    end
    space = size_zero ? '0 : eff_size - SzW'(1) - cnt;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          out_d.accepted    = acc;
          out_d.read_data   = '0;
          out_d.data_count  = CntW'(cnt);
          out_d.free_space  = CntW'(space);
          out_d.is_full     = size_zero || (space == '0);
          out_d.is_empty    = !size_zero && (wr_ptr_d == rd_ptr_d);
          out_d.burst_count = burst_cur;
          out_valid_d       = !rd_acc;
          state_d           = rd_acc ? StRead : StIdle;
        end else if (out_valid_q && out_ready_i) begin
          out_valid_d = 1'b0;
        end
      end
      StRead: begin
        out_d.read_data = ram_rdata;
        out_valid_d     = 1'b1;
        state_d         = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      burst_q     <= '0;
      size_q      <= SzQW'(Depth);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q   <= SzQW'(cfg_wdata_i);
        wr_ptr_q <= '0;
        rd_ptr_q <= '0;
        burst_q  <= '0;
      end else begin
        wr_ptr_q <= wr_ptr_d;
        rd_ptr_q <= rd_ptr_d;
        burst_q  <= burst_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  brf_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_acc),
    .re_i    (rd_acc),
    .addr_i  (rd_acc ? rd_ptr_q : wr_ptr_q),
    .wdata_i (in_data_i.data_in),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
